FILE: rtl/rgb_to_hsv_converter_unit_assert.svh
// Assertion macros for the RGB to HSV converter.
// Used by the top level; the using scope must provide clk and arst_n.
`ifndef RGB_TO_HSV_CONVERTER_UNIT_ASSERT_SVH
`define RGB_TO_HSV_CONVERTER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RTHC_ASSERT_HOLDS(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RTHC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/rthc_pkg.sv
// Shared types and constants of the RGB to HSV converter.
// No dependencies; every other file of the block but the assertion macro header uses it.
`default_nettype none

package rthc_pkg;

	localparam int CH_W       = 8;
	localparam int HUE_W      = 13;
	localparam int SAT_W      = 16;
	localparam int VAL_W      = 8;
	// One quotient bit per cell; both divisions give at most 16 quotient bits.
	localparam int DIV_STEPS  = 16;
	localparam int DIVIDEND_W = CH_W + DIV_STEPS;

	// Hue constants in whole degrees.
	localparam int DEG_GREEN  = 120;
	localparam int DEG_BLUE   = 240;
	localparam int DEG_FULL   = 360;
	localparam int HUE_SLOPE  = 60;

	typedef enum logic [1:0] {
		SEC_RED,
		SEC_GREEN,
		SEC_BLUE
	} sector_t;

	// Partial remainder and the shared dividend / quotient shift register.
	typedef struct packed {
		logic [CH_W-1:0]      rem;
		logic [DIV_STEPS-1:0] dq;
	} lane_t;

	typedef struct packed {
		lane_t           hue;
		lane_t           sat;
		logic [CH_W-1:0] delta;
		logic [CH_W-1:0] maxc;
		sector_t         sector;
		logic            neg;
	} cell_word_t;

	typedef struct packed {
		logic       valid;
		cell_word_t word;
	} link_t;

endpackage

`default_nettype wire

FILE: rtl/rthc_pix_if.sv
// Input channel of the RGB to HSV converter: one RGB pixel per word.
// Depends on rthc_pkg for the channel width.
`default_nettype none

interface rthc_pix_if;
	logic                      valid;
	logic                      ready;
	logic [rthc_pkg::CH_W-1:0] red;
	logic [rthc_pkg::CH_W-1:0] green;
	logic [rthc_pkg::CH_W-1:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

FILE: rtl/rthc_hsv_if.sv
// Output channel of the RGB to HSV converter: hue, saturation and value per word.
// Depends on rthc_pkg for the field widths.
`default_nettype none

interface rthc_hsv_if;
	logic                       valid;
	logic                       ready;
	logic [rthc_pkg::HUE_W-1:0] hue;
	logic [rthc_pkg::SAT_W-1:0] saturation;
	logic [rthc_pkg::VAL_W-1:0] value;

	modport source (output valid, output hue, output saturation, output value, input ready);
	modport sink (input valid, input hue, input saturation, input value, output ready);
endinterface

`default_nettype wire

FILE: rtl/rthc_prep.sv
// Front stage: picks the largest channel, the spread and the sector, and
// forms both dividends. Depends on rthc_pkg and rthc_pix_if.
`default_nettype none

module rthc_prep #(
	parameter int HUE_FRAC_BITS = 4
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	rthc_pix_if.sink             pix,
	output rthc_pkg::link_t      down,
	input  wire logic            down_ready
);

	// |diff| * 60 stays below 2**14 before scaling to hue units.
	localparam int X_W = 14 + HUE_FRAC_BITS;

	logic                            valid_s1;
	rthc_pkg::cell_word_t            word_s1;
	logic                            load;

	logic [rthc_pkg::CH_W-1:0]       r, g, b;
	logic [rthc_pkg::CH_W-1:0]       maxc, minc, delta, mag;
	logic signed [rthc_pkg::CH_W:0]  diff;
	rthc_pkg::sector_t               sector;
	logic [X_W-1:0]                  hue_x;
	logic [rthc_pkg::DIVIDEND_W-1:0] hue_dvd, sat_dvd;
	rthc_pkg::cell_word_t            word_next;

	assign r = pix.red;
	assign g = pix.green;
	assign b = pix.blue;

	always_comb begin
		// Red wins ties against blue, green wins all other ties.
		if (r > g && r >= b) begin
			sector = rthc_pkg::SEC_RED;
			maxc   = r;
			diff   = $signed({1'b0, g}) - $signed({1'b0, b});
		end else if (b > g) begin
			sector = rthc_pkg::SEC_BLUE;
			maxc   = b;
			diff   = $signed({1'b0, r}) - $signed({1'b0, g});
		end else begin
			sector = rthc_pkg::SEC_GREEN;
			maxc   = g;
			diff   = $signed({1'b0, b}) - $signed({1'b0, r});
		end
		minc = r;
		if (g < minc) begin
			minc = g;
		end
		if (b < minc) begin
			minc = b;
		end
		delta = maxc - minc;
		mag   = diff[rthc_pkg::CH_W] ? rthc_pkg::CH_W'(-diff) : diff[rthc_pkg::CH_W-1:0];

		hue_x   = (X_W'(mag) * X_W'(rthc_pkg::HUE_SLOPE)) << HUE_FRAC_BITS;
		hue_dvd = rthc_pkg::DIVIDEND_W'(hue_x);
		// delta * 65535 as a shift and a subtract.
		sat_dvd = (rthc_pkg::DIVIDEND_W'(delta) << rthc_pkg::DIV_STEPS)
			- rthc_pkg::DIVIDEND_W'(delta);

		word_next.hue.rem = hue_dvd[rthc_pkg::DIVIDEND_W-1:rthc_pkg::DIV_STEPS];
		word_next.hue.dq  = hue_dvd[rthc_pkg::DIV_STEPS-1:0];
		word_next.sat.rem = sat_dvd[rthc_pkg::DIVIDEND_W-1:rthc_pkg::DIV_STEPS];
		word_next.sat.dq  = sat_dvd[rthc_pkg::DIV_STEPS-1:0];
		word_next.delta   = delta;
		word_next.maxc    = maxc;
		word_next.sector  = sector;
		word_next.neg     = diff[rthc_pkg::CH_W];
	end

	assign load      = !valid_s1 || down_ready;
	assign pix.ready = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= pix.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && pix.valid) begin
			word_s1 <= word_next;
		end
	end

	assign down.valid = valid_s1;
	assign down.word  = word_s1;

endmodule

`default_nettype wire

FILE: rtl/rthc_cell.sv
// One cell of the divider row: a restoring step for the hue and the
// saturation quotient, registered. Depends on rthc_pkg.
`default_nettype none

module rthc_cell (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire rthc_pkg::link_t  up,
	output logic                  up_ready,
	output rthc_pkg::link_t       down,
	input  wire logic             down_ready
);

	logic                 valid_q;
	rthc_pkg::cell_word_t word_q;
	rthc_pkg::cell_word_t word_next;
	logic                 load;

	// Shift the next dividend bit into the remainder, subtract if it fits,
	// and shift the quotient bit in at the bottom.
	function automatic rthc_pkg::lane_t div_step(rthc_pkg::lane_t l,
		logic [rthc_pkg::CH_W-1:0] d);
		logic [rthc_pkg::CH_W:0] t;
		logic                    ge;
		rthc_pkg::lane_t         n;
		t     = {l.rem, l.dq[rthc_pkg::DIV_STEPS-1]};
		ge    = t >= {1'b0, d};
		n.rem = ge ? rthc_pkg::CH_W'(t - {1'b0, d}) : t[rthc_pkg::CH_W-1:0];
		n.dq  = {l.dq[rthc_pkg::DIV_STEPS-2:0], ge};
		return n;
	endfunction

	always_comb begin
		word_next     = up.word;
		word_next.hue = div_step(up.word.hue, up.word.delta);
		word_next.sat = div_step(up.word.sat, up.word.maxc);
	end

	assign load     = !valid_q || down_ready;
	assign up_ready = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= up.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && up.valid) begin
			word_q <= word_next;
		end
	end

	assign down.valid = valid_q;
	assign down.word  = word_q;

endmodule

`default_nettype wire

FILE: rtl/rgb_to_hsv_converter_unit.sv
// RGB to HSV converter, top level. Depends on rthc_pkg, rthc_pix_if,
// rthc_hsv_if, rthc_prep, rthc_cell and the assertion macro header.
//
// The pix channel takes one 8-bit RGB pixel per word; the hsv channel gives
// one word per pixel, in order: hue in units of 1/2**HUE_FRAC_BITS degree,
// saturation with 65535 as full scale, and value as the largest channel.
// Both channels use valid/ready; a word moves when both are high.
//
// The path from acceptance to the result word being offered is one front
// stage, a row of 16 divider cells that each settle one quotient bit of
// both divisions, and one output register. The row of cells sets the
// latency; throughput is one pixel per clock while hsv.ready stays high.
//
// Every stage holds its word until the next stage can take it, so bubbles
// close up when the receiver stalls, and the input keeps accepting until
// all stages are full. Reset clears only the valid flags: the block comes
// out of reset empty and ready, with no clearing pass.
`default_nettype none
`include "rgb_to_hsv_converter_unit_assert.svh"

module rgb_to_hsv_converter_unit #(
	parameter int HUE_FRAC_BITS = 4
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	rthc_pix_if.sink     pix,
	rthc_hsv_if.source   hsv
);

	// Wide enough for the full hue before it is cut to the field width.
	localparam int HUE_CALC_W = (9 + HUE_FRAC_BITS > 16) ? 9 + HUE_FRAC_BITS : 16;

	rthc_pkg::link_t chain [0:rthc_pkg::DIV_STEPS];
	logic            chain_ready [0:rthc_pkg::DIV_STEPS];

	// The front stage computes the extremes and both dividends.
	rthc_prep #(
		.HUE_FRAC_BITS(HUE_FRAC_BITS)
	) u_prep (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix        (pix),
		.down       (chain[0]),
		.down_ready (chain_ready[0])
	);

	// The divider row; each cell passes its word to the next one.
	for (genvar i = 0; i < rthc_pkg::DIV_STEPS; i++) begin : g_cell
		rthc_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.up         (chain[i]),
			.up_ready   (chain_ready[i]),
			.down       (chain[i+1]),
			.down_ready (chain_ready[i+1])
		);
	end

	// Final assembly of the hue and the output register.
	rthc_pkg::cell_word_t         last;
	logic                         out_valid_q;
	logic [rthc_pkg::HUE_W-1:0]   hue_q;
	logic [rthc_pkg::SAT_W-1:0]   sat_q;
	logic [rthc_pkg::VAL_W-1:0]   val_q;
	logic                         fin_load;
	logic                         grey;
	logic                         frac;
	logic [HUE_CALC_W-1:0]        quot;
	logic [HUE_CALC_W-1:0]        offset;
	logic [HUE_CALC_W-1:0]        hue_calc;
	logic [rthc_pkg::HUE_W-1:0]   hue_next;
	logic [rthc_pkg::SAT_W-1:0]   sat_next;

	assign last = chain[rthc_pkg::DIV_STEPS].word;

	always_comb begin
		grey = last.delta == '0;
		frac = last.hue.rem != '0;
		quot = HUE_CALC_W'(last.hue.dq);
		// A negative hue in the red sector wraps around by a full circle.
		case (last.sector)
			rthc_pkg::SEC_RED:
				offset = last.neg ? HUE_CALC_W'(rthc_pkg::DEG_FULL) << HUE_FRAC_BITS : '0;
			rthc_pkg::SEC_GREEN:
				offset = HUE_CALC_W'(rthc_pkg::DEG_GREEN) << HUE_FRAC_BITS;
			rthc_pkg::SEC_BLUE:
				offset = HUE_CALC_W'(rthc_pkg::DEG_BLUE) << HUE_FRAC_BITS;
			default:
				offset = '0;
		endcase
		// For a negative difference the quotient of the magnitude is rounded
		// up before it is subtracted, which floors the signed quotient.
		if (last.neg) begin
			hue_calc = offset - quot - HUE_CALC_W'(frac);
		end else begin
			hue_calc = offset + quot;
		end
		hue_next = grey ? '0 : hue_calc[rthc_pkg::HUE_W-1:0];
		sat_next = grey ? '0 : last.sat.dq;
	end

	assign fin_load                        = !out_valid_q || hsv.ready;
	assign chain_ready[rthc_pkg::DIV_STEPS] = fin_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_load) begin
			out_valid_q <= chain[rthc_pkg::DIV_STEPS].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_load && chain[rthc_pkg::DIV_STEPS].valid) begin
			hue_q <= hue_next;
			sat_q <= sat_next;
			val_q <= last.maxc;
		end
	end

	assign hsv.valid      = out_valid_q;
	assign hsv.hue        = hue_q;
	assign hsv.saturation = sat_q;
	assign hsv.value      = val_q;

	// The assembled hue of a colored pixel stays below a full circle.
	`RTHC_ASSERT_HOLDS(a_hue_below_circle, fin_load && chain[rthc_pkg::DIV_STEPS].valid && !grey, hue_calc < (HUE_CALC_W'(rthc_pkg::DEG_FULL) << HUE_FRAC_BITS), "hue reached a full circle")
	// Zero saturation only comes from a grey pixel, whose hue is zero.
	`RTHC_ASSERT_HOLDS(a_grey_hue, hsv.valid && hsv.saturation == '0, hsv.hue == '0, "grey result with nonzero hue")
	// The input only stalls when every stage is full behind a stalled output.
	`RTHC_ASSERT_HOLDS(a_stall_source, !pix.ready, hsv.valid && !hsv.ready, "input stalled with room in the row")
	// A full row keeps a result on offer in the following cycle.
	`RTHC_ASSERT_NEXT(a_full_row_holds, !pix.ready, hsv.valid, "result vanished from a full row")

endmodule

`default_nettype wire

FILE: verif/tb_rgb_to_hsv_converter_unit.sv
// Self-checking testbench for the RGB to HSV converter top level.
// Depends on rthc_pkg, rthc_pix_if, rthc_hsv_if and rgb_to_hsv_converter_unit; it drives
// directed and random pixel words, predicts each hue/saturation/value word and checks it in order.

module tb_rgb_to_hsv_converter_unit;

	localparam int HUE_FRAC_BITS = 4;

	// Hue geometry in whole degrees and the saturation full scale, kept apart from the
	// package so that a wrong constant there shows up as a mismatch here.
	localparam longint HUE_GREEN_BASE = 120;
	localparam longint HUE_BLUE_BASE  = 240;
	localparam longint HUE_TURN       = 360;
	localparam longint HUE_PER_SIDE   = 60;
	localparam longint SAT_SCALE      = 65535;

	localparam int RANDOM_PIXELS  = 1300;
	// Cycles without any word moving on either channel before the run is abandoned.
	// The longest legal quiet stretch is the receiver hold-off below.
	localparam int IDLE_LIMIT     = 1000;
	localparam int HOLD_CYCLES    = 120;
	// Longer than the pipeline takes to offer a result after it takes a pixel.
	localparam int SETTLE_CYCLES  = 40;

	// Receiver behaviors; each lasts for a random number of cycles.
	typedef enum logic [1:0] {
		RX_FREE,
		RX_LIGHT,
		RX_HALF,
		RX_PERIODIC
	} rx_mode_t;

	// A pixel waiting to be sent. When wait_drain is set, the sender holds this pixel
	// back until every result of the earlier pixels has come out.
	typedef struct packed {
		logic [rthc_pkg::CH_W-1:0] red;
		logic [rthc_pkg::CH_W-1:0] green;
		logic [rthc_pkg::CH_W-1:0] blue;
		logic                      wait_drain;
	} pixel_word_t;

	typedef struct packed {
		logic [rthc_pkg::HUE_W-1:0] hue;
		logic [rthc_pkg::SAT_W-1:0] saturation;
		logic [rthc_pkg::VAL_W-1:0] value;
	} hsv_word_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// The channel inputs are held in local variables with known start values, so the
	// block never sees an unknown input, even before the first clock edge.
	logic                      pix_valid = 1'b0;
	logic [rthc_pkg::CH_W-1:0] pix_red   = '0;
	logic [rthc_pkg::CH_W-1:0] pix_green = '0;
	logic [rthc_pkg::CH_W-1:0] pix_blue  = '0;
	logic                      hsv_ready = 1'b0;

	rthc_pix_if pix_ch ();
	rthc_hsv_if hsv_ch ();

	assign pix_ch.valid = pix_valid;
	assign pix_ch.red   = pix_red;
	assign pix_ch.green = pix_green;
	assign pix_ch.blue  = pix_blue;
	assign hsv_ch.ready = hsv_ready;

	rgb_to_hsv_converter_unit #(
		.HUE_FRAC_BITS(HUE_FRAC_BITS)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix_ch),
		.hsv    (hsv_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	pixel_word_t pixel_q[$];
	hsv_word_t   hsv_expect_q[$];
	// Copy of the number of results still owed, updated with a nonblocking assignment so
	// that other processes read a value that is settled for the whole clock edge.
	int          hsv_outstanding;
	int          mismatches = 0;

	// Works out the hue, saturation and value of one pixel. The hue is formed as an exact
	// fraction over the channel spread, wrapped by a full turn when it comes out negative
	// (only possible when red is largest), and then truncated to whole hue units.
	function automatic hsv_word_t hsv_of_pixel(input logic [rthc_pkg::CH_W-1:0] r8,
		input logic [rthc_pkg::CH_W-1:0] g8, input logic [rthc_pkg::CH_W-1:0] b8);
		rthc_pkg::sector_t sector;
		longint    r, g, b, maxc, minc, spread, base, side, num, unit, hue_units, sat;
		hsv_word_t res;
		r = longint'(r8);
		g = longint'(g8);
		b = longint'(b8);
		// Red wins ties with blue but not with green; blue wins only when above green.
		if (r > g && r >= b) begin
			sector = rthc_pkg::SEC_RED;
		end else if (b > g) begin
			sector = rthc_pkg::SEC_BLUE;
		end else begin
			sector = rthc_pkg::SEC_GREEN;
		end
		case (sector)
			rthc_pkg::SEC_RED: begin
				maxc = r;
				base = 0;
				side = g - b;
			end
			rthc_pkg::SEC_BLUE: begin
				maxc = b;
				base = HUE_BLUE_BASE;
				side = r - g;
			end
			default: begin
				maxc = g;
				base = HUE_GREEN_BASE;
				side = b - r;
			end
		endcase
		minc = r;
		if (g < minc) minc = g;
		if (b < minc) minc = b;
		spread = maxc - minc;
		unit = longint'(1) << HUE_FRAC_BITS;
		res = '0;
		res.value = maxc[rthc_pkg::VAL_W-1:0];
		// A grey pixel has neither hue nor saturation.
		if (spread > 0) begin
			num = base * unit * spread + side * HUE_PER_SIDE * unit;
			if (num < 0) num += HUE_TURN * unit * spread;
			hue_units = num / spread;
			sat = (spread * SAT_SCALE) / maxc;
			res.hue = hue_units[rthc_pkg::HUE_W-1:0];
			res.saturation = sat[rthc_pkg::SAT_W-1:0];
		end
		return res;
	endfunction

	function automatic logic [rthc_pkg::CH_W-1:0] extreme_level();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return rthc_pkg::CH_W'(1);
			2: return {rthc_pkg::CH_W{1'b1}} - 1'b1;
			default: return {rthc_pkg::CH_W{1'b1}};
		endcase
	endfunction

	// Random pixel. Half are uniform; the rest aim at the corners of the arithmetic:
	// near-grey pixels with a spread of a few steps, channels at the ends of their range,
	// two equal channels (the sector tie rules) and a saturated largest channel.
	function automatic pixel_word_t rand_pixel(input logic wait_drain);
		pixel_word_t px;
		int          lvl;
		logic [rthc_pkg::CH_W-1:0] a, b;
		px.wait_drain = wait_drain;
		case ($urandom_range(0, 9))
			5, 6: begin
				lvl = $urandom_range(2, 253);
				px.red   = rthc_pkg::CH_W'(lvl + $urandom_range(0, 4) - 2);
				px.green = rthc_pkg::CH_W'(lvl + $urandom_range(0, 4) - 2);
				px.blue  = rthc_pkg::CH_W'(lvl + $urandom_range(0, 4) - 2);
			end
			7: begin
				px.red   = extreme_level();
				px.green = extreme_level();
				px.blue  = extreme_level();
			end
			8: begin
				a = rthc_pkg::CH_W'($urandom_range(0, 255));
				b = rthc_pkg::CH_W'($urandom_range(0, 255));
				case ($urandom_range(0, 2))
					0: begin px.red = a; px.green = a; px.blue = b; end
					1: begin px.red = a; px.green = b; px.blue = a; end
					default: begin px.red = b; px.green = a; px.blue = a; end
				endcase
			end
			9: begin
				px.red   = rthc_pkg::CH_W'($urandom_range(0, 255));
				px.green = rthc_pkg::CH_W'($urandom_range(0, 255));
				px.blue  = rthc_pkg::CH_W'($urandom_range(0, 255));
				case ($urandom_range(0, 2))
					0: px.red = '1;
					1: px.green = '1;
					default: px.blue = '1;
				endcase
			end
			default: begin
				px.red   = rthc_pkg::CH_W'($urandom_range(0, 255));
				px.green = rthc_pkg::CH_W'($urandom_range(0, 255));
				px.blue  = rthc_pkg::CH_W'($urandom_range(0, 255));
			end
		endcase
		return px;
	endfunction

	task automatic queue_pixel(input int r, input int g, input int b);
		pixel_word_t px;
		px.red = rthc_pkg::CH_W'(r);
		px.green = rthc_pkg::CH_W'(g);
		px.blue = rthc_pkg::CH_W'(b);
		px.wait_drain = 1'b0;
		pixel_q.push_back(px);
	endtask

	// Sender. It offers the pixel at the head of the queue and keeps it steady until the
	// block takes it; only then does it pick the next one or start a gap. Bursts of
	// random length alternate with gaps, and a gap of zero lets bursts run together.
	int gap_left;
	int burst_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid <= 1'b0;
			pix_red   <= '0;
			pix_green <= '0;
			pix_blue  <= '0;
			gap_left   = 0;
			burst_left = $urandom_range(1, 40);
		end else if (!pix_valid || pix_ch.ready) begin
			if (pix_valid) begin
				void'(pixel_q.pop_front());
			end
			if (gap_left > 0) begin
				gap_left--;
				pix_valid <= 1'b0;
			end else if (pixel_q.size() == 0) begin
				pix_valid <= 1'b0;
			end else if (pixel_q[0].wait_drain && (pix_valid || hsv_outstanding != 0)) begin
				// A word taken at this edge is not yet counted as owed, so wait while one
				// has just moved as well as while results are still on their way.
				pix_valid <= 1'b0;
			end else begin
				pix_valid <= 1'b1;
				pix_red   <= pixel_q[0].red;
				pix_green <= pixel_q[0].green;
				pix_blue  <= pixel_q[0].blue;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 60);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end
		end
	end

	// Receiver. It switches between a few stall patterns. Twice in the run, after a set
	// number of results, it refuses words for a long stretch so that the pipeline fills
	// and the input stalls while the sender keeps offering.
	rx_mode_t rx_mode;
	int       mode_left;
	int       hold_left;
	int       rx_phase;
	int       words_taken;
	int       next_hold_at;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hsv_ready    <= 1'b0;
			rx_mode       = RX_FREE;
			mode_left     = 0;
			hold_left     = 0;
			rx_phase      = 0;
			words_taken   = 0;
			next_hold_at  = 400;
		end else begin
			if (hsv_ch.valid && hsv_ready) words_taken++;
			rx_phase++;
			if (hold_left > 0) begin
				hold_left--;
				hsv_ready <= 1'b0;
			end else if (words_taken >= next_hold_at) begin
				hold_left    = HOLD_CYCLES - 1;
				next_hold_at = next_hold_at + 600;
				hsv_ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					rx_mode   = rx_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(20, 200);
				end
				mode_left--;
				case (rx_mode)
					RX_FREE:     hsv_ready <= 1'b1;
					RX_LIGHT:    hsv_ready <= ($urandom_range(0, 3) != 0);
					RX_HALF:     hsv_ready <= ($urandom_range(0, 1) != 0);
					default:     hsv_ready <= ((rx_phase % 5) < 2);
				endcase
			end
		end
	end

	// Monitor. On each accepted pixel it stores the predicted result word; on each
	// accepted result word it checks the oldest prediction field by field.
	always @(posedge clk or negedge arst_n) begin
		hsv_word_t want;
		if (!arst_n) begin
			hsv_outstanding <= 0;
		end else begin
			if (pix_valid && pix_ch.ready) begin
				hsv_expect_q.push_back(hsv_of_pixel(pix_red, pix_green, pix_blue));
			end
			if (hsv_ch.valid && hsv_ready) begin
				if (hsv_expect_q.size() == 0) begin
					$error("result word with no pixel waiting: hue %0d saturation %0d value %0d",
						hsv_ch.hue, hsv_ch.saturation, hsv_ch.value);
					mismatches++;
				end else begin
					want = hsv_expect_q.pop_front();
					if (hsv_ch.hue !== want.hue) begin
						$error("hue: expected %0d, got %0d", want.hue, hsv_ch.hue);
						mismatches++;
					end
					if (hsv_ch.saturation !== want.saturation) begin
						$error("saturation: expected %0d, got %0d", want.saturation,
							hsv_ch.saturation);
						mismatches++;
					end
					if (hsv_ch.value !== want.value) begin
						$error("value: expected %0d, got %0d", want.value, hsv_ch.value);
						mismatches++;
					end
				end
			end
			hsv_outstanding <= hsv_expect_q.size();
		end
	end

	// Watchdog: a run in which no word moves on either channel for too long is stuck.
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((pix_valid && pix_ch.ready) || (hsv_ch.valid && hsv_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles == IDLE_LIMIT) begin
				$display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		int i;
		// Directed pixels: black, white and grey; each primary; the red sector with a
		// hue just below a full turn, which needs the wrap; every tie between channels;
		// the smallest spreads at both ends of the range; alternating bit patterns.
		queue_pixel(0, 0, 0);
		queue_pixel(255, 255, 255);
		queue_pixel(77, 77, 77);
		queue_pixel(1, 1, 1);
		queue_pixel(255, 0, 0);
		queue_pixel(0, 255, 0);
		queue_pixel(0, 0, 255);
		queue_pixel(255, 0, 1);
		queue_pixel(255, 1, 0);
		queue_pixel(255, 0, 255);
		queue_pixel(255, 255, 0);
		queue_pixel(0, 255, 255);
		queue_pixel(1, 0, 0);
		queue_pixel(0, 1, 0);
		queue_pixel(0, 0, 1);
		queue_pixel(255, 254, 254);
		queue_pixel(254, 255, 254);
		queue_pixel(254, 254, 255);
		queue_pixel(170, 85, 170);
		queue_pixel(85, 170, 85);
		queue_pixel(254, 0, 255);
		queue_pixel(128, 127, 129);

		// Random pixels. A few of them wait until the pipeline has drained, which splits
		// the run into phases and exercises a restart from empty.
		for (i = 0; i < RANDOM_PIXELS; i++) begin
			pixel_q.push_back(rand_pixel(i == 0 || i == 300 || i == 800));
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Checked on the falling edge, when every queue and counter has settled.
		while (pixel_q.size() != 0 || hsv_outstanding != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);

		if (hsv_expect_q.size() != 0) begin
			$error("%0d result words never arrived", hsv_expect_q.size());
			mismatches += hsv_expect_q.size();
		end
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

FILE: sim.f
+incdir+rtl
rtl/rthc_pkg.sv
rtl/rthc_pix_if.sv
rtl/rthc_hsv_if.sv
rtl/rthc_prep.sv
rtl/rthc_cell.sv
rtl/rgb_to_hsv_converter_unit.sv
verif/tb_rgb_to_hsv_converter_unit.sv
